@@ sv/fhau_pkg.sv @@
// Shared constants, types and a helper function of the four-way histogram accumulator.
`timescale 1ns / 1ps

package fhau_pkg;

   localparam int T_BITS = 10;
   localparam int T_BINS = 2 ** T_BITS;
   localparam int S_BITS = 16;
   localparam int S_BINS = 2 ** S_BITS;
   localparam int X_BITS = 11;
   localparam int X_BINS = 2 ** X_BITS;

   localparam int TS_BITS  = (T_BITS > S_BITS) ? T_BITS : S_BITS;
   localparam int CLR_BITS = (TS_BITS > X_BITS) ? TS_BITS : X_BITS;

   localparam int CNT_W     = 32;
   localparam int DUR_W     = 16;
   localparam int VAL_W     = 32;
   localparam int EXT_W     = 16;
   localparam int SEL_W     = 2;
   localparam int IDX_W     = 16;
   localparam int LAT_W     = 10;
   localparam int WIN_W     = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [LAT_W-1:0] LATTICE_RESET = LAT_W'(64);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LATTICE_SIZE,
      CSR_WINDOW_INDEX
   } csr_index_type;

   typedef enum logic {
      CMD_ACCUMULATE,
      CMD_READ
   } cmd_type;

   typedef enum logic [SEL_W-1:0] {
      HIST_DURATION,
      HIST_SIZE,
      HIST_AREA,
      HIST_EXTENT
   } hist_type;

   typedef struct packed {
      logic              rd_en;
      logic [T_BITS-1:0] dur_addr;
      logic [S_BITS-1:0] size_addr;
      logic [S_BITS-1:0] area_addr;
      logic [X_BITS-1:0] ext_addr;
   } bank_addr_type;

   typedef struct packed {
      logic              dur_we;
      logic              size_we;
      logic              area_we;
      logic              ext_we;
      logic [T_BITS-1:0] dur_addr;
      logic [S_BITS-1:0] size_addr;
      logic [S_BITS-1:0] area_addr;
      logic [X_BITS-1:0] ext_addr;
      logic [CNT_W-1:0]  dur_data;
      logic [CNT_W-1:0]  size_data;
      logic [CNT_W-1:0]  area_data;
      logic [CNT_W-1:0]  ext_data;
   } bank_wr_type;

   typedef struct packed {
      logic [CNT_W-1:0] dur;
      logic [CNT_W-1:0] size;
      logic [CNT_W-1:0] area;
      logic [CNT_W-1:0] ext;
   } bank_data_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
   endfunction

endpackage

@@ sv/fhau_req_if.sv @@
// Request channel interface carrying record and read transactions.
`timescale 1ns / 1ps

interface fhau_req_if import fhau_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [DUR_W-1:0] duration;
   logic [VAL_W-1:0] size_value;
   logic [VAL_W-1:0] area_value;
   logic [EXT_W-1:0] extent;
   logic [SEL_W-1:0] hist_select;
   logic [IDX_W-1:0] bin_index;

   modport source (output valid, cmd, duration, size_value, area_value, extent,
                   hist_select, bin_index, input ready);
   modport sink (input valid, cmd, duration, size_value, area_value, extent,
                 hist_select, bin_index, output ready);
endinterface

@@ sv/fhau_rsp_if.sv @@
// Response channel interface carrying result transactions.
`timescale 1ns / 1ps

interface fhau_rsp_if import fhau_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] bin_count;
   logic [DUR_W-1:0] duration_max;
   logic [VAL_W-1:0] size_max;
   logic [VAL_W-1:0] area_max;
   logic [EXT_W-1:0] extent_max;
   logic [CNT_W-1:0] record_total;
   logic             size_beyond;
   logic             area_beyond;
   logic             extent_overflow;

   modport source (output valid, bin_count, duration_max, size_max, area_max, extent_max,
                   record_total, size_beyond, area_beyond, extent_overflow, input ready);
   modport sink (input valid, bin_count, duration_max, size_max, area_max, extent_max,
                 record_total, size_beyond, area_beyond, extent_overflow, output ready);
endinterface

@@ sv/fhau_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module fhau_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/fhau_bank.sv @@
// Bank of the four histogram memories with the post-reset clearing sweep.
`timescale 1ns / 1ps

module fhau_bank import fhau_pkg::*; (
   input  logic                clock,
   input  logic                clear_en,
   input  logic [CLR_BITS-1:0] clear_addr,
   input  bank_addr_type       rd_ctl,
   input  bank_wr_type         wr_ctl,
   output bank_data_type       rd_data
);

   logic              dur_we;
   logic              size_we;
   logic              area_we;
   logic              ext_we;
   logic [T_BITS-1:0] dur_waddr;
   logic [S_BITS-1:0] size_waddr;
   logic [S_BITS-1:0] area_waddr;
   logic [X_BITS-1:0] ext_waddr;
   logic [CNT_W-1:0]  dur_wdata;
   logic [CNT_W-1:0]  size_wdata;
   logic [CNT_W-1:0]  area_wdata;
   logic [CNT_W-1:0]  ext_wdata;

   always_comb begin
      dur_we     = clear_en | wr_ctl.dur_we;
      size_we    = clear_en | wr_ctl.size_we;
      area_we    = clear_en | wr_ctl.area_we;
      ext_we     = clear_en | wr_ctl.ext_we;
      dur_waddr  = clear_en ? clear_addr[T_BITS-1:0] : wr_ctl.dur_addr;
      size_waddr = clear_en ? clear_addr[S_BITS-1:0] : wr_ctl.size_addr;
      area_waddr = clear_en ? clear_addr[S_BITS-1:0] : wr_ctl.area_addr;
      ext_waddr  = clear_en ? clear_addr[X_BITS-1:0] : wr_ctl.ext_addr;
      dur_wdata  = clear_en ? '0 : wr_ctl.dur_data;
      size_wdata = clear_en ? '0 : wr_ctl.size_data;
      area_wdata = clear_en ? '0 : wr_ctl.area_data;
      ext_wdata  = clear_en ? '0 : wr_ctl.ext_data;
   end

   fhau_ram #(.WIDTH(CNT_W), .DEPTH(T_BINS)) u_dur_ram (
      .clock (clock),
      .we    (dur_we),
      .waddr (dur_waddr),
      .wdata (dur_wdata),
      .re    (rd_ctl.rd_en),
      .raddr (rd_ctl.dur_addr),
      .rdata (rd_data.dur)
   );

   fhau_ram #(.WIDTH(CNT_W), .DEPTH(S_BINS)) u_size_ram (
      .clock (clock),
      .we    (size_we),
      .waddr (size_waddr),
      .wdata (size_wdata),
      .re    (rd_ctl.rd_en),
      .raddr (rd_ctl.size_addr),
      .rdata (rd_data.size)
   );

   fhau_ram #(.WIDTH(CNT_W), .DEPTH(S_BINS)) u_area_ram (
      .clock (clock),
      .we    (area_we),
      .waddr (area_waddr),
      .wdata (area_wdata),
      .re    (rd_ctl.rd_en),
      .raddr (rd_ctl.area_addr),
      .rdata (rd_data.area)
   );

   fhau_ram #(.WIDTH(CNT_W), .DEPTH(X_BINS)) u_ext_ram (
      .clock (clock),
      .we    (ext_we),
      .waddr (ext_waddr),
      .wdata (ext_wdata),
      .re    (rd_ctl.rd_en),
      .raddr (rd_ctl.ext_addr),
      .rdata (rd_data.ext)
   );

endmodule

@@ sv/four_way_histogram_accumulator_unit.sv @@
// Top level of the four-way histogram accumulator: control, maxima, counters and flags.
//
// Channel    Direction  Handshake        Contents
// req_chan   in         valid/ready      cmd, duration, size, area, extent, hist_select, bin_index
// rsp_chan   out        valid/ready      bin_count, four maxima, record_total, three flags
// csr_*      in         write enable     lattice_size (index 0), window_index (index 1)
//
// The accept cycle reads all four histogram memories, and the update state does the
// read-modify-write through their write ports and loads the result once any waiting one is taken.
// After reset a clearing pass over all 2**CLR_BITS addresses (65536) zeroes the memories; no
// transaction is accepted during it, while configuration writes are taken at any time.
// A transaction is accepted while an earlier result waits; its update then holds until the
// waiting result is taken.
`timescale 1ns / 1ps

module four_way_histogram_accumulator_unit import fhau_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   fhau_req_if.sink             req_chan,
   fhau_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type           state_ff;
   logic [CLR_BITS-1:0] clr_cnt_ff;
   logic                rsp_valid_ff;
   logic [CNT_W-1:0]    bin_ff;
   logic [CNT_W-1:0]    bin_in;

   logic                cmd_ff;
   logic [DUR_W-1:0]    dur_ff;
   logic [VAL_W-1:0]    size_ff;
   logic [VAL_W-1:0]    area_ff;
   logic [EXT_W-1:0]    ext_ff;
   logic [SEL_W-1:0]    sel_ff;
   logic [IDX_W-1:0]    idx_ff;
   bank_addr_type       addr_ff;

   logic [LAT_W-1:0]    lattice_ff;
   logic [WIN_W-1:0]    window_ff;
   logic [DUR_W-1:0]    dmax_ff;
   logic [DUR_W-1:0]    dmax_in;
   logic [VAL_W-1:0]    smax_ff;
   logic [VAL_W-1:0]    smax_in;
   logic [VAL_W-1:0]    amax_ff;
   logic [VAL_W-1:0]    amax_in;
   logic [EXT_W-1:0]    xmax_ff;
   logic [EXT_W-1:0]    xmax_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                sbeyond_ff;
   logic                sbeyond_in;
   logic                abeyond_ff;
   logic                abeyond_in;
   logic                xovf_ff;
   logic                xovf_in;

   logic                accept;
   logic                fire;
   logic                rec_ok;
   logic                dur_in_range;
   logic                ext_in_range;
   logic [VAL_W-1:0]    size_hi;
   logic [VAL_W-1:0]    area_hi;
   logic [VAL_W-1:0]    win_ext;
   bank_addr_type       rd_ctl;
   bank_wr_type         wr_ctl;
   bank_data_type       rd_data;

   assign accept         = req_chan.valid & req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign fire           = (state_ff == ST_UPDATE) & (~rsp_valid_ff | rsp_chan.ready);

   always_comb begin
      rd_ctl.rd_en = accept;
      if (cmd_type'(req_chan.cmd) == CMD_READ) begin
         rd_ctl.dur_addr  = T_BITS'(req_chan.bin_index);
         rd_ctl.size_addr = S_BITS'(req_chan.bin_index);
         rd_ctl.area_addr = S_BITS'(req_chan.bin_index);
         rd_ctl.ext_addr  = X_BITS'(req_chan.bin_index);
      end else begin
         rd_ctl.dur_addr  = T_BITS'(req_chan.duration);
         rd_ctl.size_addr = req_chan.size_value[S_BITS-1:0];
         rd_ctl.area_addr = req_chan.area_value[S_BITS-1:0];
         rd_ctl.ext_addr  = X_BITS'(req_chan.extent);
      end
   end

   always_comb begin
      rec_ok       = (cmd_type'(cmd_ff) == CMD_ACCUMULATE) && (dur_ff != '0)
                     && (dur_ff <= DUR_W'(lattice_ff));
      dur_in_range = 32'(dur_ff) < 32'(T_BINS);
      ext_in_range = 32'(ext_ff) < 32'(X_BINS);
      size_hi      = VAL_W'(size_ff >> S_BITS);
      area_hi      = VAL_W'(area_ff >> S_BITS);
      win_ext      = VAL_W'(window_ff);

      wr_ctl.dur_addr  = addr_ff.dur_addr;
      wr_ctl.size_addr = addr_ff.size_addr;
      wr_ctl.area_addr = addr_ff.area_addr;
      wr_ctl.ext_addr  = addr_ff.ext_addr;
      wr_ctl.dur_data  = sat_inc(rd_data.dur);
      wr_ctl.size_data = sat_inc(rd_data.size);
      wr_ctl.area_data = sat_inc(rd_data.area);
      wr_ctl.ext_data  = sat_inc(rd_data.ext);
      wr_ctl.dur_we    = fire & rec_ok & dur_in_range;
      wr_ctl.size_we   = fire & rec_ok & (size_hi == win_ext);
      wr_ctl.area_we   = fire & rec_ok & (area_hi == win_ext);
      wr_ctl.ext_we    = fire & rec_ok & ext_in_range;

      dmax_in    = dmax_ff;
      smax_in    = smax_ff;
      amax_in    = amax_ff;
      xmax_in    = xmax_ff;
      count_in   = count_ff;
      sbeyond_in = sbeyond_ff;
      abeyond_in = abeyond_ff;
      xovf_in    = xovf_ff;
      if (rec_ok) begin
         if (dur_ff > dmax_ff) begin
            dmax_in = dur_ff;
         end
         if (size_ff > smax_ff) begin
            smax_in = size_ff;
         end
         if (area_ff > amax_ff) begin
            amax_in = area_ff;
         end
         if (ext_ff > xmax_ff) begin
            xmax_in = ext_ff;
         end
         count_in   = sat_inc(count_ff);
         sbeyond_in = sbeyond_ff | (size_hi > win_ext);
         abeyond_in = abeyond_ff | (area_hi > win_ext);
         xovf_in    = xovf_ff | ~ext_in_range;
      end

      bin_in = '0;
      if (cmd_type'(cmd_ff) == CMD_READ) begin
         if (idx_ff == '0) begin
            bin_in = count_ff;
         end else begin
            case (hist_type'(sel_ff))
               HIST_DURATION: bin_in = (32'(idx_ff) < 32'(T_BINS)) ? rd_data.dur : '0;
               HIST_SIZE:     bin_in = (32'(idx_ff) < 32'(S_BINS)) ? rd_data.size : '0;
               HIST_AREA:     bin_in = (32'(idx_ff) < 32'(S_BINS)) ? rd_data.area : '0;
               HIST_EXTENT:   bin_in = (32'(idx_ff) < 32'(X_BINS)) ? rd_data.ext : '0;
               default:       bin_in = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + CLR_BITS'(1);
               if (clr_cnt_ff == {CLR_BITS{1'b1}}) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (fire) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  bin_ff       <= bin_in;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_chan.cmd;
         dur_ff  <= req_chan.duration;
         size_ff <= req_chan.size_value;
         area_ff <= req_chan.area_value;
         ext_ff  <= req_chan.extent;
         sel_ff  <= req_chan.hist_select;
         idx_ff  <= req_chan.bin_index;
         addr_ff <= rd_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lattice_ff <= LATTICE_RESET;
         window_ff  <= '0;
         dmax_ff    <= '0;
         smax_ff    <= '0;
         amax_ff    <= '0;
         xmax_ff    <= '0;
         count_ff   <= '0;
         sbeyond_ff <= 1'b0;
         abeyond_ff <= 1'b0;
         xovf_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_LATTICE_SIZE: lattice_ff <= csr_wdata[LAT_W-1:0];
               CSR_WINDOW_INDEX: window_ff  <= csr_wdata[WIN_W-1:0];
               default: begin
               end
            endcase
         end
         if (fire) begin
            dmax_ff    <= dmax_in;
            smax_ff    <= smax_in;
            amax_ff    <= amax_in;
            xmax_ff    <= xmax_in;
            count_ff   <= count_in;
            sbeyond_ff <= sbeyond_in;
            abeyond_ff <= abeyond_in;
            xovf_ff    <= xovf_in;
         end
      end
   end

   fhau_bank u_bank (
      .clock      (clock),
      .clear_en   (state_ff == ST_CLEAR),
      .clear_addr (clr_cnt_ff),
      .rd_ctl     (rd_ctl),
      .wr_ctl     (wr_ctl),
      .rd_data    (rd_data)
   );

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.bin_count       = bin_ff;
   assign rsp_chan.duration_max    = dmax_ff;
   assign rsp_chan.size_max        = smax_ff;
   assign rsp_chan.area_max        = amax_ff;
   assign rsp_chan.extent_max      = xmax_ff;
   assign rsp_chan.record_total    = count_ff;
   assign rsp_chan.size_beyond     = sbeyond_ff;
   assign rsp_chan.area_beyond     = abeyond_ff;
   assign rsp_chan.extent_overflow = xovf_ff;

   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_UPDATE)
      else $error("Accepted transaction did not enter the update state.");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_UPDATE)
      else $error("Result appeared without an update.");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff >= $past(count_ff))
      else $error("Record count decreased.");

   a_write_only_on_update: assert property (@(posedge clock) disable iff (reset)
      (wr_ctl.dur_we || wr_ctl.size_we || wr_ctl.area_we || wr_ctl.ext_we)
      |-> rsp_valid_ff == 1'b0 || rsp_chan.ready)
      else $error("Histogram written while the previous result was still held.");

endmodule
